// File: design/armax_residual_filter_assert.svh
// Assertion macros for the ARMAX residual filter.
`ifndef ARMAX_RESIDUAL_FILTER_ASSERT_SVH
`define ARMAX_RESIDUAL_FILTER_ASSERT_SVH
// A condition that must hold whenever reset is released.
`define ARF_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);
// A condition that implies another in the next cycle.
`define ARF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

// File: design/arf_pkg.sv
// ----------------------------------------------------------------------------
// arf_pkg
// Types, constants and helpers shared by the ARMAX residual filter modules.
// ----------------------------------------------------------------------------
`default_nettype none
package arf_pkg;
    localparam int DEF_MAX_AR      = 4;
    localparam int DEF_MAX_EXOG    = 4;
    localparam int DEF_MAX_MA      = 4;
    localparam int DEF_MAX_LAG     = 16;
    localparam int DEF_SAMPLE_BITS = 32;
    localparam int EXOG_INPUTS     = 4;

    localparam logic [2:0] REG_HAS_CONST = 3'd0;
    localparam logic [2:0] REG_AR_COUNT  = 3'd1;
    localparam logic [2:0] REG_EXOG_CNT  = 3'd2;
    localparam logic [2:0] REG_MA_COUNT  = 3'd3;
    localparam logic [2:0] REG_WARMUP    = 3'd4;
    localparam logic [2:0] REG_CONST     = 3'd5;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_LOAD   = 1'b1;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] y_sample;
        logic signed [31:0] exog_0;
        logic signed [31:0] exog_1;
        logic signed [31:0] exog_2;
        logic signed [31:0] exog_3;
        logic [30:0]        sigma_value;
        logic [3:0]         slot;
        logic signed [31:0] coef_value;
        logic [4:0]         lag_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] scaled_residual;
        logic signed [31:0] raw_residual;
        logic               saturated;
        logic               sigma_zero;
        logic               in_warmup;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MAC, ST_ROUND, ST_DIV, ST_OUT
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic       start;     // latch item, preset accumulator from sample and constant
        logic       mac;       // one product step
        logic [5:0] term;      // term index of the product step
        logic       round;     // round and saturate the sum
        logic       div_start;
        logic       div_step;
        logic       commit;    // push histories, load output register
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic warm;            // the latched sample lies in the warmup window
        logic div_skip;        // sigma zero: no division needed
    } dp_stat_t;
endpackage
`default_nettype wire

// File: design/arf_ctrl.sv
// ----------------------------------------------------------------------------
// arf_ctrl
// Sequencer: walks the product terms, the divider steps and the output hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
module arf_ctrl
    import arf_pkg::*;
#(
    parameter int NTERMS = 12
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire logic     s_mode,
    input  wire logic     out_busy,   // output register still holds a beat
    output dp_cmd_t       cmd,
    input  wire dp_stat_t stat
);
    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [5:0] dcnt_reg, dcnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            dcnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dcnt_next  = dcnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_mode == MODE_SAMPLE) begin
                    state_next = ST_MAC;
                    cnt_next   = '0;
                end
            end
            ST_MAC: begin
                // The last count issues no product; it lets the final one land.
                if (stat.warm) begin
                    state_next = ST_OUT;
                end else if (cnt_reg == 6'(NTERMS)) begin
                    state_next = ST_ROUND;
                end else begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            ST_ROUND: begin
                state_next = ST_DIV;
                dcnt_next  = '0;
            end
            ST_DIV: begin
                if (stat.div_skip || dcnt_reg == 6'd48) begin
                    state_next = ST_OUT;
                end else begin
                    dcnt_next = dcnt_reg + 6'd1;
                end
            end
            ST_OUT: begin
                if (!out_busy) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd       = '0;
        s_ready   = 1'b0;
        cmd.term  = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.start = s_valid && s_mode == MODE_SAMPLE;
            end
            ST_MAC:   cmd.mac = !stat.warm && cnt_reg < 6'(NTERMS);
            ST_ROUND: cmd.round = 1'b1;
            ST_DIV: begin
                cmd.div_start = dcnt_reg == 6'd0;
                cmd.div_step  = dcnt_reg != 6'd0;
            end
            ST_OUT:   cmd.commit = !out_busy;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// File: design/arf_datapath.sv
// ----------------------------------------------------------------------------
// arf_datapath
// Coefficient and history storage, one multiply-accumulate, restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none
module arf_datapath
    import arf_pkg::*;
#(
    parameter int MAX_AR      = DEF_MAX_AR,
    parameter int MAX_EXOG    = DEF_MAX_EXOG,
    parameter int MAX_MA      = DEF_MAX_MA,
    parameter int MAX_LAG     = DEF_MAX_LAG,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire in_item_t    in_item,
    input  wire logic        load_en,
    input  wire logic        cfg_has_const,
    input  wire logic [2:0]  cfg_ar,
    input  wire logic [2:0]  cfg_exog,
    input  wire logic [2:0]  cfg_ma,
    input  wire logic [15:0] cfg_warmup,
    input  wire logic [31:0] cfg_const,
    input  wire dp_cmd_t     cmd,
    output dp_stat_t         stat,
    output out_item_t        result
);
    localparam int NCOEF = MAX_AR + MAX_EXOG + MAX_MA;
    localparam int NLAG  = MAX_AR + MAX_MA;
    localparam int SATB  = SAMPLE_BITS > 32 ? 32 : SAMPLE_BITS;
    localparam int EXLIM = MAX_EXOG < EXOG_INPUTS ? MAX_EXOG : EXOG_INPUTS;
    localparam int LW    = $clog2(MAX_LAG);
    localparam int CW    = $clog2(NCOEF);
    localparam int GW    = $clog2(NLAG);
    localparam logic signed [63:0] SAT_HI = 64'sd2 ** (SATB - 1) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    logic signed [31:0] coef_reg [NCOEF];
    logic [4:0]         lag_reg  [NLAG];
    logic signed [31:0] yh_reg   [MAX_LAG];
    logic signed [31:0] rh_reg   [MAX_LAG];
    logic [15:0]        scount_reg;
    in_item_t           item_reg;
    logic signed [63:0] acc_reg;
    logic signed [31:0] raw_reg;
    logic               sat_reg;
    logic               warm_reg;
    logic signed [31:0] oper_reg;    // multiplier operands, registered
    logic signed [31:0] mcoef_reg;
    logic               mvalid_reg;
    // Divider: magnitude quotient of |raw|*2^16 / sigma, one bit a step.
    logic [47:0]        dnum_reg;
    logic [31:0]        drem_reg;
    logic               dneg_reg;
    out_item_t          result_next;

    function automatic logic [LW-1:0] lag_idx(input logic [4:0] l);
        logic [8:0] v;
        v = {4'd0, l};
        if (v == 9'd0) v = 9'd1;
        if (v > 9'(MAX_LAG)) v = 9'(MAX_LAG);
        lag_idx = LW'(v - 9'd1);
    endfunction

    function automatic logic [2:0] cap3(input logic [2:0] v, input int m);
        cap3 = (32'(v) > m) ? 3'(m) : v;
    endfunction

    logic [2:0] nar, nex, nma;
    assign nar = cap3(cfg_ar, MAX_AR);
    assign nex = cap3(cfg_exog, EXLIM);
    assign nma = cap3(cfg_ma, MAX_MA);

    assign stat.warm     = scount_reg < cfg_warmup;
    assign stat.div_skip = item_reg.sigma_value == '0;

    // Operand selection for the current term.
    logic signed [31:0] sel_oper, sel_coef;
    logic               sel_use;
    always_comb begin
        int t;
        t        = int'(cmd.term);
        sel_oper = '0;
        sel_coef = '0;
        sel_use  = 1'b0;
        if (t < NCOEF) sel_coef = coef_reg[CW'(t)];
        if (t < MAX_AR) begin
            sel_oper = yh_reg[lag_idx(lag_reg[GW'(t)])];
            sel_use  = t < int'(nar);
        end else if (t < MAX_AR + MAX_EXOG) begin
            case (t - MAX_AR)
                0: sel_oper = item_reg.exog_0;
                1: sel_oper = item_reg.exog_1;
                2: sel_oper = item_reg.exog_2;
                3: sel_oper = item_reg.exog_3;
                default: sel_oper = '0;
            endcase
            sel_use = (t - MAX_AR) < int'(nex);
        end else if (t < NCOEF) begin
            sel_oper = rh_reg[lag_idx(lag_reg[GW'(t - MAX_EXOG)])];
            sel_use  = (t - MAX_AR - MAX_EXOG) < int'(nma);
        end
    end

    logic signed [63:0] prod;
    assign prod = 64'(mcoef_reg) * 64'(oper_reg);

    logic signed [63:0] rnd;
    assign rnd = (acc_reg + 64'sd32768) >>> 16;

    logic [31:0] sig32;
    logic [32:0] trial;
    logic [31:0] rmag;
    assign sig32 = {1'b0, item_reg.sigma_value};
    assign trial = {drem_reg, dnum_reg[47]} - {1'b0, sig32};
    assign rmag  = raw_reg[31] ? 32'(-raw_reg) : 32'(raw_reg);

    // Final quotient: magnitude up to 48 bits, sign applied, then saturated.
    logic signed [63:0] quo;
    assign quo = dneg_reg ? -$signed({16'd0, dnum_reg}) : $signed({16'd0, dnum_reg});

    always_comb begin
        result_next = '0;
        if (warm_reg) begin
            result_next.in_warmup = 1'b1;
        end else begin
            result_next.raw_residual = raw_reg;
            if (stat.div_skip) begin
                result_next.sigma_zero = 1'b1;
                result_next.saturated  = sat_reg;
                result_next.scaled_residual = raw_reg == 0 ? 32'sd0 :
                    (raw_reg[31] ? 32'(SAT_LO) : 32'(SAT_HI));
            end else if (quo > SAT_HI) begin
                result_next.scaled_residual = 32'(SAT_HI);
                result_next.saturated = 1'b1;
            end else if (quo < SAT_LO) begin
                result_next.scaled_residual = 32'(SAT_LO);
                result_next.saturated = 1'b1;
            end else begin
                result_next.scaled_residual = 32'(quo);
                result_next.saturated = sat_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NCOEF; i++) coef_reg[i] <= '0;
            for (int i = 0; i < NLAG; i++) lag_reg[i] <= 5'd1;
            for (int i = 0; i < MAX_LAG; i++) begin
                yh_reg[i] <= '0;
                rh_reg[i] <= '0;
            end
            scount_reg <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            if (load_en && int'(in_item.slot) < NCOEF) begin
                coef_reg[CW'(in_item.slot)] <= in_item.coef_value;
                if (int'(in_item.slot) < MAX_AR)
                    lag_reg[GW'(in_item.slot)] <= in_item.lag_value;
                else if (int'(in_item.slot) >= MAX_AR + MAX_EXOG)
                    lag_reg[GW'(int'(in_item.slot) - MAX_EXOG)] <= in_item.lag_value;
            end
            mvalid_reg <= cmd.mac && sel_use;
            if (cmd.commit) begin
                for (int i = MAX_LAG - 1; i > 0; i--) begin
                    yh_reg[i] <= yh_reg[i-1];
                    rh_reg[i] <= rh_reg[i-1];
                end
                yh_reg[0] <= item_reg.y_sample;
                rh_reg[0] <= warm_reg ? 32'sd0 : raw_reg;
                if (warm_reg) scount_reg <= scount_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            item_reg <= in_item;
            acc_reg  <= (64'(in_item.y_sample) <<< 16)
                        - (cfg_has_const ? (64'($signed(cfg_const)) <<< 16) : 64'sd0);
            sat_reg  <= 1'b0;
        end else if (mvalid_reg) begin
            // Product is Q.40; floor to Q.32 before subtracting.
            acc_reg <= acc_reg - (prod >>> 8);
        end
        if (cmd.mac) begin
            oper_reg  <= sel_oper;
            mcoef_reg <= sel_coef;
            warm_reg  <= 1'b0;
        end
        if (cmd.start) warm_reg <= 1'b1;
        if (cmd.round) begin
            warm_reg <= 1'b0;
            if (rnd > SAT_HI) begin
                raw_reg <= 32'(SAT_HI);
                sat_reg <= 1'b1;
            end else if (rnd < SAT_LO) begin
                raw_reg <= 32'(SAT_LO);
                sat_reg <= 1'b1;
            end else begin
                raw_reg <= 32'(rnd);
            end
        end
        if (cmd.div_start) begin
            dnum_reg <= {rmag, 16'd0};
            drem_reg <= '0;
            dneg_reg <= raw_reg[31];
        end else if (cmd.div_step) begin
            if (!trial[32]) begin
                drem_reg <= trial[31:0];
                dnum_reg <= {dnum_reg[46:0], 1'b1};
            end else begin
                drem_reg <= {drem_reg[30:0], dnum_reg[47]};
                dnum_reg <= {dnum_reg[46:0], 1'b0};
            end
        end
        if (cmd.commit) result <= result_next;
    end
endmodule
`default_nettype wire

// File: design/armax_residual_filter.sv
// ----------------------------------------------------------------------------
// armax_residual_filter
// ARMAX residual filter with Q16.16 samples and Q8.24 coefficients.
// ----------------------------------------------------------------------------
// Usage: items arrive on s_valid/s_ready/s_data. A load beat (mode 1) writes
// one coefficient slot and yields no result. A sample beat
// (mode 0) yields one beat on m_valid/m_ready/m_data.
// A sample runs one product per term slot through a single registered
// multiplier, a rounding step and a one-bit-per-cycle restoring divider of
// 48 steps, skipped when sigma is zero. Warmup samples skip the products,
// the rounding and the divider.
// The result sits in an output register; the next item is accepted while it
// waits, and a sample is only held at its final stage if the register is
// still full. Configuration goes through the APB port, written while idle.
// Reset clears histories and coefficients, sets all lags to one and clears
// the sample counter, the configuration registers and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none
module armax_residual_filter
    import arf_pkg::*;
#(
    parameter int MAX_AR      = DEF_MAX_AR,
    parameter int MAX_EXOG    = DEF_MAX_EXOG,
    parameter int MAX_MA      = DEF_MAX_MA,
    parameter int MAX_LAG     = DEF_MAX_LAG,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic        has_const_reg;
    logic [2:0]  ar_reg, exog_reg, ma_reg;
    logic [15:0] warmup_reg;
    logic [31:0] const_reg;
    logic        m_valid_reg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [2:0]  ridx;

    assign pready = 1'b1;
    assign ridx   = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            has_const_reg <= 1'b0;
            ar_reg        <= '0;
            exog_reg      <= '0;
            ma_reg        <= '0;
            warmup_reg    <= '0;
            const_reg     <= '0;
        end else if (psel && penable && pwrite) begin
            case (ridx)
                REG_HAS_CONST: has_const_reg <= pwdata[0];
                REG_AR_COUNT:  ar_reg        <= pwdata[2:0];
                REG_EXOG_CNT:  exog_reg      <= pwdata[2:0];
                REG_MA_COUNT:  ma_reg        <= pwdata[2:0];
                REG_WARMUP:    warmup_reg    <= pwdata[15:0];
                REG_CONST:     const_reg     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (ridx)
            REG_HAS_CONST: prdata = {31'd0, has_const_reg};
            REG_AR_COUNT:  prdata = {29'd0, ar_reg};
            REG_EXOG_CNT:  prdata = {29'd0, exog_reg};
            REG_MA_COUNT:  prdata = {29'd0, ma_reg};
            REG_WARMUP:    prdata = {16'd0, warmup_reg};
            REG_CONST:     prdata = const_reg;
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end
    assign m_valid = m_valid_reg;

    arf_ctrl #(
        .NTERMS(MAX_AR + MAX_EXOG + MAX_MA)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_mode   (s_data.mode),
        .out_busy (m_valid_reg && !m_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    arf_datapath #(
        .MAX_AR      (MAX_AR),
        .MAX_EXOG    (MAX_EXOG),
        .MAX_MA      (MAX_MA),
        .MAX_LAG     (MAX_LAG),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_item       (s_data),
        .load_en       (s_valid && s_ready && s_data.mode == MODE_LOAD),
        .cfg_has_const (has_const_reg),
        .cfg_ar        (ar_reg),
        .cfg_exog      (exog_reg),
        .cfg_ma        (ma_reg),
        .cfg_warmup    (warmup_reg),
        .cfg_const     (const_reg),
        .cmd           (cmd),
        .stat          (stat),
        .result        (m_data)
    );

`include "armax_residual_filter_assert.svh"
    `ARF_ASSERT_ALWAYS(a_no_commit_while_full, aclk, aresetn, !(cmd.commit && m_valid_reg && !m_ready), "result overwritten before it was taken")
    `ARF_ASSERT_NEXT(a_commit_gives_valid, aclk, aresetn, cmd.commit, m_valid, "committed result not presented")
    `ARF_ASSERT_ALWAYS(a_one_command, aclk, aresetn, $onehot0({cmd.start, cmd.mac, cmd.round, cmd.div_start, cmd.div_step, cmd.commit}), "controller issued overlapping commands")
endmodule
`default_nettype wire

// File: tb/armax_residual_filter_tb.sv
// ----------------------------------------------------------------------------
// armax_residual_filter_tb
// Self-checking bench for the ARMAX residual filter. Coefficient loads,
// register writes over APB and sample beats are driven with random idle
// bursts on both channels. A scoreboard class predicts each residual beat
// from its own copy of histories, coefficients and registers, and compares
// it field by field with the beats that the block produces.
// ----------------------------------------------------------------------------
`default_nettype none

class residual_scoreboard;
    bit [2:0] ar_n, ex_n, ma_n;
    bit has_c;
    bit [15:0] warm_n, warm_seen;
    logic signed [31:0] c_coef;
    logic signed [31:0] y_hist [16];
    logic signed [31:0] r_hist [16];
    logic signed [31:0] coefs [12];
    bit [4:0] lags [8];
    arf_pkg::out_item_t pending [$];
    int errors;

    function void clear();
        ar_n = 0; ex_n = 0; ma_n = 0; has_c = 0; warm_n = 0; warm_seen = 0;
        c_coef = 0; errors = 0;
        foreach (y_hist[i]) begin
            y_hist[i] = 0;
            r_hist[i] = 0;
        end
        foreach (coefs[i]) coefs[i] = 0;
        foreach (lags[i]) lags[i] = 1;
    endfunction

    function void set_reg(int idx, logic [31:0] v);
        case (idx)
            arf_pkg::REG_HAS_CONST: has_c = v[0];
            arf_pkg::REG_AR_COUNT:  ar_n = v[2:0];
            arf_pkg::REG_EXOG_CNT:  ex_n = v[2:0];
            arf_pkg::REG_MA_COUNT:  ma_n = v[2:0];
            arf_pkg::REG_WARMUP:    warm_n = v[15:0];
            arf_pkg::REG_CONST:     c_coef = v;
            default: ;
        endcase
    endfunction

    // Floor division of a 64-bit product by 2^8; the arithmetic shift floors.
    function longint prod_q32(logic signed [31:0] c, logic signed [31:0] x);
        longint p;
        p = longint'(c) * longint'(x);
        return p >>> 8;
    endfunction

    function int eff_lag(bit [4:0] l);
        if (l == 0) return 1;
        if (l > 16) return 16;
        return l;
    endfunction

    function void shift_in(logic signed [31:0] y, logic signed [31:0] r);
        for (int i = 15; i > 0; i--) begin
            y_hist[i] = y_hist[i-1];
            r_hist[i] = r_hist[i-1];
        end
        y_hist[0] = y;
        r_hist[0] = r;
    endfunction

    function void note_input(arf_pkg::in_item_t it);
        arf_pkg::out_item_t o;
        longint acc, raw, sc, hi, lo;
        logic signed [31:0] xs [4];
        int na, ne, nm;
        if (it.mode == arf_pkg::MODE_LOAD) begin
            if (it.slot < 12) begin
                coefs[it.slot] = it.coef_value;
                if (it.slot < 4) lags[it.slot] = it.lag_value;
                else if (it.slot >= 8) lags[it.slot - 4] = it.lag_value;
            end
            return;
        end
        o = '0;
        if (warm_seen < warm_n) begin
            warm_seen++;
            shift_in(it.y_sample, 0);
            o.in_warmup = 1;
            pending.push_back(o);
            return;
        end
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        xs[0] = it.exog_0; xs[1] = it.exog_1; xs[2] = it.exog_2; xs[3] = it.exog_3;
        na = (ar_n > 4) ? 4 : ar_n;
        ne = (ex_n > 4) ? 4 : ex_n;
        nm = (ma_n > 4) ? 4 : ma_n;
        acc = longint'(it.y_sample) * 65536;
        if (has_c) acc -= longint'(c_coef) * 65536;
        for (int i = 0; i < na; i++)
            acc -= prod_q32(coefs[i], y_hist[eff_lag(lags[i]) - 1]);
        for (int i = 0; i < ne; i++)
            acc -= prod_q32(coefs[4 + i], xs[i]);
        for (int i = 0; i < nm; i++)
            acc -= prod_q32(coefs[8 + i], r_hist[eff_lag(lags[4 + i]) - 1]);
        raw = (acc + 32768) >>> 16;
        if (raw > hi) begin raw = hi; o.saturated = 1; end
        if (raw < lo) begin raw = lo; o.saturated = 1; end
        if (it.sigma_value == 0) begin
            o.sigma_zero = 1;
            sc = (raw > 0) ? hi : ((raw < 0) ? lo : 0);
        end else begin
            // SystemVerilog division truncates toward zero.
            sc = (raw * 65536) / longint'({1'b0, it.sigma_value});
            if (sc > hi) begin sc = hi; o.saturated = 1; end
            if (sc < lo) begin sc = lo; o.saturated = 1; end
        end
        o.scaled_residual = sc[31:0];
        o.raw_residual = raw[31:0];
        shift_in(it.y_sample, raw[31:0]);
        pending.push_back(o);
    endfunction

    function void check_result(arf_pkg::out_item_t got);
        arf_pkg::out_item_t e;
        if (pending.size() == 0) begin
            $error("result beat with no expectation: %h", got);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.scaled_residual !== e.scaled_residual) begin
            $error("scaled_residual exp %0d got %0d", e.scaled_residual, got.scaled_residual);
            errors++;
        end
        if (got.raw_residual !== e.raw_residual) begin
            $error("raw_residual exp %0d got %0d", e.raw_residual, got.raw_residual);
            errors++;
        end
        if (got.saturated !== e.saturated) begin
            $error("saturated exp %0d got %0d", e.saturated, got.saturated);
            errors++;
        end
        if (got.sigma_zero !== e.sigma_zero) begin
            $error("sigma_zero exp %0d got %0d", e.sigma_zero, got.sigma_zero);
            errors++;
        end
        if (got.in_warmup !== e.in_warmup) begin
            $error("in_warmup exp %0d got %0d", e.in_warmup, got.in_warmup);
            errors++;
        end
    endfunction
endclass

module armax_residual_filter_tb;
    import arf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 0;
    out_item_t m_data;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    residual_scoreboard residuals;
    bit quiet_tail = 0;
    int idle_cycles = 0;

    always #6 aclk = ~aclk;

    armax_residual_filter uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Result side: random stall bursts, then always ready near the end.
    initial begin
        int gap;
        residuals = new();
        residuals.clear();
        forever begin
            @(posedge aclk);
            if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                m_ready <= 0;
                gap = $urandom_range(1, 17);
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) residuals.check_result(m_data);
        if (aresetn && !((s_valid && s_ready) || (m_valid && m_ready) || psel))
            idle_cycles <= idle_cycles + 1;
        else
            idle_cycles <= 0;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[armax_residual_filter] ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        residuals.set_reg(idx, v);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge aclk);
    endtask

    // Valid stays high from one beat to the next unless an idle burst is taken.
    task automatic send(input in_item_t it);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        residuals.note_input(it);
    endtask

    function automatic in_item_t rand_item();
        in_item_t it;
        logic [255:0] raw_bits;
        raw_bits = {$urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom};
        it = raw_bits[$bits(in_item_t)-1:0];
        return it;
    endfunction

    // Small values keep residuals out of saturation most of the time.
    function automatic logic signed [31:0] modest(input int bits);
        logic signed [31:0] v;
        v = $urandom;
        return v >>> (32 - bits);
    endfunction

    task automatic load(input logic [3:0] sl, input logic signed [31:0] c,
                        input logic [4:0] lg);
        in_item_t it;
        it = rand_item();
        it.mode = MODE_LOAD; it.slot = sl; it.coef_value = c; it.lag_value = lg;
        send(it);
    endtask

    task automatic sample(input logic signed [31:0] y, input logic [30:0] sg);
        in_item_t it;
        it = rand_item();
        it.mode = MODE_SAMPLE; it.y_sample = y; it.sigma_value = sg;
        it.exog_0 = modest(24); it.exog_1 = modest(24);
        it.exog_2 = modest(24); it.exog_3 = modest(24);
        send(it);
    endtask

    task automatic drain();
        while (residuals.pending.size() != 0) @(posedge aclk);
        @(negedge s_ready);
        repeat (80) @(posedge aclk);
    endtask

    task automatic drain_idle();
        int n;
        n = 0;
        s_valid <= 0;
        while (residuals.pending.size() != 0 && n < 200000) begin
            @(posedge aclk);
            n++;
        end
        repeat (100) @(posedge aclk);
    endtask

    initial begin
        in_item_t it;
        int phase_items;
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: warmup, extremes, zero sigma, odd lags and out-of-range slots.
        write_reg(REG_WARMUP, 2);
        write_reg(REG_HAS_CONST, 1);
        write_reg(REG_CONST, 32'h8000_0000);
        write_reg(REG_AR_COUNT, 4);
        write_reg(REG_EXOG_CNT, 4);
        write_reg(REG_MA_COUNT, 4);
        load(0, 32'h0080_0000, 1);
        load(1, 32'h7FFF_FFFF, 0);
        load(2, 32'h8000_0000, 31);
        load(3, 32'hFF00_0000, 16);
        load(4, 32'h0100_0000, 5);
        load(8, 32'h0040_0000, 2);
        load(11, 32'hFFC0_0000, 17);
        load(12, 32'h1234_5678, 3);
        load(15, 32'h7FFF_FFFF, 3);
        sample(32'sh7FFF_FFFF, 31'h7FFF_FFFF);
        sample(32'sh8000_0000, 31'd1);
        sample(32'sh7FFF_FFFF, 31'd0);
        sample(32'sh8000_0000, 31'd0);
        sample(32'sh0001_0000, 31'd1);
        sample(32'sh0000_0000, 31'd0);
        sample(32'sh0002_0000, 31'h0001_0000);
        drain_idle();

        // Random phases, each with its own register setting.
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(REG_HAS_CONST, $urandom_range(0, 1));
            write_reg(REG_AR_COUNT, (ph == 1) ? 7 : $urandom_range(0, 7));
            write_reg(REG_EXOG_CNT, (ph == 2) ? 0 : $urandom_range(0, 7));
            write_reg(REG_MA_COUNT, (ph == 3) ? 7 : $urandom_range(0, 7));
            write_reg(REG_WARMUP, (ph == 4) ? 16'hFFFF : $urandom_range(0, 5));
            write_reg(REG_CONST, (ph == 5) ? 32'h7FFF_FFFF : modest(22));
            phase_items = 75;
            if (ph == 9) quiet_tail = 1;
            for (int k = 0; k < phase_items; k++) begin
                it = rand_item();
                case ($urandom_range(0, 9))
                    0: ; // raw random beat, any field value
                    1, 2: begin
                        it.mode = MODE_LOAD;
                        it.slot = 4'($urandom_range(0, 13));
                        it.coef_value = modest($urandom_range(20, 32));
                    end
                    default: begin
                        it.mode = MODE_SAMPLE;
                        it.y_sample = modest($urandom_range(18, 32));
                        it.exog_0 = modest(24); it.exog_1 = modest(24);
                        it.exog_2 = modest(24); it.exog_3 = modest(24);
                        if ($urandom_range(0, 15) == 0) it.sigma_value = 0;
                        else it.sigma_value = 31'($urandom_range(1, 31'h0010_0000)
                                                  >> $urandom_range(0, 12));
                        if ($urandom_range(0, 20) == 0) it.sigma_value = 31'($urandom);
                    end
                endcase
                send(it);
            end
            drain_idle();
        end

        drain_idle();
        if (residuals.errors == 0 && residuals.pending.size() == 0) begin
            $display("[armax_residual_filter] OK");
        end else begin
            if (residuals.pending.size() != 0)
                $error("%0d expected beats never arrived", residuals.pending.size());
            $display("[armax_residual_filter] ERROR");
        end
        $finish;
    end
endmodule

`default_nettype wire
